/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* sv/iir_tdf2_pkg.sv */
// ----------------------------------------------------------------------------
// iir_tdf2_pkg
// shared types and constants of the transposed direct form ii iir filter
// ----------------------------------------------------------------------------
package iir_tdf2_pkg;

    localparam int ORDER_DEF    = 3;
    localparam int CHANNELS_DEF = 8;

    localparam int SW  = 24;    // sample and coefficient width
    localparam int CHW = 3;     // channel tag width
    localparam int ZW  = 48;    // delay word width
    localparam int AW_ACC = 50; // accumulator width
    localparam int JW  = 2;     // delay tap index width
    localparam int CIW = 3;     // config index width
    localparam int NUM_COEF = 7;

    localparam logic [CIW-1:0] CFG_COEF_B0 = 3'd0;
    localparam logic [CIW-1:0] CFG_COEF_B1 = 3'd1;
    localparam logic [CIW-1:0] CFG_COEF_B2 = 3'd2;
    localparam logic [CIW-1:0] CFG_COEF_B3 = 3'd3;
    localparam logic [CIW-1:0] CFG_COEF_A1 = 3'd4;
    localparam logic [CIW-1:0] CFG_COEF_A2 = 3'd5;
    localparam logic [CIW-1:0] CFG_COEF_A3 = 3'd6;

    localparam logic signed [SW-1:0] COEF_B0_RST = 24'sd1048576;

    typedef struct packed {
        logic          in_load;
        logic          rd_en;
        logic [JW-1:0] rd_idx;
        logic          wr_en;
        logic [JW-1:0] wr_idx;
        logic          mul_en;
        logic          mul_y;
        logic          mul_fb;
        logic [JW-1:0] mul_idx;
        logic          acc_load;
        logic          acc_add_z;
        logic          y_en;
        logic          mark_valid;
        logic          out_load;
    } t_cmd;

endpackage

/* sv/iir_tdf2_ctrl.sv */
// ----------------------------------------------------------------------------
// iir_tdf2_ctrl
// sequencer that steps the shared multiplier through one sample
// ----------------------------------------------------------------------------
module iir_tdf2_ctrl
    import iir_tdf2_pkg::*;
#(
    parameter int ORDER = ORDER_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_B0,
        S_Z0,
        S_Y,
        S_FA,
        S_FB,
        S_FC,
        S_OUT
    } t_state;

    localparam logic [JW:0] ORD = (JW+1)'(ORDER);

    t_state        r_state, n_state;
    logic [JW-1:0] r_j, n_j;
    logic          r_out_vld, n_out_vld;
    logic [JW:0]   jx;
    logic [JW:0]   jn;
    t_cmd          cmd;

    assign jx = {1'b0, r_j};
    assign jn = jx + (JW+1)'(1);

    always_comb begin
        cmd       = '0;
        n_state   = r_state;
        n_j       = r_j;
        n_out_vld = r_out_vld;
        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.in_load = 1'b1;
                    n_j         = JW'(1);
                    n_state     = S_B0;
                end
            end
            S_B0: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_idx  = JW'(0);
                cmd.mul_en  = 1'b1;
                cmd.mul_idx = JW'(0);
                n_state     = S_Z0;
            end
            S_Z0: begin
                cmd.acc_load  = 1'b1;
                cmd.acc_add_z = 1'b1;
                cmd.rd_en     = (ORD > (JW+1)'(1));
                cmd.rd_idx    = JW'(1);
                cmd.mul_en    = 1'b1;
                cmd.mul_idx   = JW'(1);
                n_state       = S_Y;
            end
            S_Y: begin
                cmd.y_en      = 1'b1;
                cmd.acc_load  = 1'b1;
                cmd.acc_add_z = (ORD > (JW+1)'(1));
                n_state       = S_FA;
            end
            S_FA: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_y   = 1'b1;
                cmd.mul_fb  = 1'b1;
                cmd.mul_idx = r_j;
                n_state     = S_FB;
            end
            S_FB: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_idx = r_j - JW'(1);
                if (jx < ORD) begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_idx = jn[JW-1:0];
                    cmd.rd_en   = (jn < ORD);
                    cmd.rd_idx  = jn[JW-1:0];
                    n_j         = jn[JW-1:0];
                    n_state     = S_FC;
                end else begin
                    cmd.mark_valid = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_FC: begin
                cmd.acc_load  = 1'b1;
                cmd.acc_add_z = (jx < ORD);
                cmd.mul_en    = 1'b1;
                cmd.mul_y     = 1'b1;
                cmd.mul_fb    = 1'b1;
                cmd.mul_idx   = r_j;
                n_state       = S_FB;
            end
            S_OUT: begin
                if (!r_out_vld || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_out_vld    = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_j       <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_j       <= n_j;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

/* sv/iir_tdf2_dp.sv */
// ----------------------------------------------------------------------------
// iir_tdf2_dp
// coefficients, delay memory, shared multiplier and accumulator
// ----------------------------------------------------------------------------
module iir_tdf2_dp
    import iir_tdf2_pkg::*;
#(
    parameter int ORDER    = ORDER_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CIW-1:0]        i_cfg_idx,
    input  logic signed [SW-1:0]  i_cfg_data,
    input  logic [CHW-1:0]        i_chan_in,
    input  logic signed [SW-1:0]  i_sample_in,
    input  t_cmd                  i_cmd,
    output logic [CHW-1:0]        o_chan_out,
    output logic signed [SW-1:0]  o_sample_out,
    output logic                  o_saturated
);

    localparam int DEPTH = CHANNELS * ORDER;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MW    = 7;

    logic signed [SW-1:0]     r_coef [NUM_COEF];
    logic [CHANNELS-1:0]      r_ch_vld;
    logic signed [ZW-1:0]     r_mem [DEPTH];
    logic signed [ZW-1:0]     r_mem_q;
    logic                     r_rd_vld;
    logic signed [SW-1:0]     r_x;
    logic [CHW-1:0]           r_chan;
    logic [CW-1:0]            r_ch;
    logic [AW-1:0]            r_base;
    logic signed [2*SW-1:0]   r_prod;
    logic signed [AW_ACC-1:0] r_acc;
    logic signed [SW-1:0]     r_y;
    logic                     r_sat;
    logic [CHW-1:0]           r_out_chan;
    logic signed [SW-1:0]     r_out_sample;
    logic                     r_out_sat;

    logic [MW-1:0]            ch_mod;
    logic [AW+JW-1:0]         base_full;
    logic [AW+JW-1:0]         rd_full;
    logic [AW+JW-1:0]         wr_full;
    logic [CIW-1:0]           coef_sel;
    logic signed [SW-1:0]     mul_a;
    logic signed [SW-1:0]     mul_b;
    logic signed [AW_ACC-1:0] prod_ext;
    logic signed [AW_ACC-1:0] z_ext;
    logic signed [AW_ACC-1:0] acc_diff;
    logic signed [ZW-1:0]     z_new;
    logic signed [AW_ACC-1:0] biased;
    logic [AW_ACC-21:0]       y_wide;
    logic                     y_fits;
    logic signed [SW-1:0]     y_new;

    // channel tag folded onto the existing delay lines
    always_comb begin
        ch_mod = {{(MW-CHW){1'b0}}, i_chan_in};
        for (int k = 0; k < 8; k++) begin
            if (ch_mod >= MW'(CHANNELS)) begin
                ch_mod = ch_mod - MW'(CHANNELS);
            end
        end
    end

    assign base_full = (AW+JW)'(ch_mod[CW-1:0]) * (AW+JW)'(ORDER);
    assign rd_full   = {{JW{1'b0}}, r_base} + {{AW{1'b0}}, i_cmd.rd_idx};
    assign wr_full   = {{JW{1'b0}}, r_base} + {{AW{1'b0}}, i_cmd.wr_idx};

    assign coef_sel = i_cmd.mul_fb ? (CFG_COEF_A1 + CIW'(i_cmd.mul_idx) - CIW'(1))
                                   : (CFG_COEF_B0 + CIW'(i_cmd.mul_idx));
    assign mul_a    = r_coef[coef_sel];
    assign mul_b    = i_cmd.mul_y ? r_y : r_x;

    assign prod_ext = {{(AW_ACC-2*SW){r_prod[2*SW-1]}}, r_prod};
    assign z_ext    = (i_cmd.acc_add_z && r_rd_vld)
                    ? {{(AW_ACC-ZW){r_mem_q[ZW-1]}}, r_mem_q} : '0;

    // new delay word, saturated to 48 bits
    assign acc_diff = r_acc - prod_ext;
    always_comb begin
        if (acc_diff[AW_ACC-1:ZW-1] == {(AW_ACC-ZW+1){acc_diff[ZW-1]}}) begin
            z_new = acc_diff[ZW-1:0];
        end else begin
            z_new = {acc_diff[AW_ACC-1], {(ZW-1){~acc_diff[AW_ACC-1]}}};
        end
    end

    // round half up to q1.23 and clip
    assign biased = r_acc + AW_ACC'(524288);
    assign y_wide = biased[AW_ACC-1:20];
    assign y_fits = (y_wide[AW_ACC-21:SW-1] == {(AW_ACC-20-SW+1){y_wide[SW-1]}});
    assign y_new  = y_fits ? y_wide[SW-1:0]
                           : {y_wide[AW_ACC-21], {(SW-1){~y_wide[AW_ACC-21]}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COEF; k++) begin
                r_coef[k] <= (k == int'(CFG_COEF_B0)) ? COEF_B0_RST : '0;
            end
            r_ch_vld <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx < CIW'(NUM_COEF))) begin
                r_coef[i_cfg_idx] <= i_cfg_data;
            end
            if (i_cmd.mark_valid) begin
                r_ch_vld[r_ch] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_mem_q  <= r_mem[rd_full[AW-1:0]];
            r_rd_vld <= r_ch_vld[r_ch];
        end
        if (i_cmd.wr_en) begin
            r_mem[wr_full[AW-1:0]] <= z_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_x    <= i_sample_in;
            r_chan <= i_chan_in;
            r_ch   <= ch_mod[CW-1:0];
            r_base <= base_full[AW-1:0];
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.acc_load) begin
            r_acc <= prod_ext + z_ext;
        end
        if (i_cmd.y_en) begin
            r_y   <= y_new;
            r_sat <= ~y_fits;
        end
        if (i_cmd.out_load) begin
            r_out_chan   <= r_chan;
            r_out_sample <= r_y;
            r_out_sat    <= r_sat;
        end
    end

    assign o_chan_out   = r_out_chan;
    assign o_sample_out = r_out_sample;
    assign o_saturated  = r_out_sat;

endmodule

/* sv/iir_filter_transposed_df2.sv */
// ----------------------------------------------------------------------------
// iir_filter_transposed_df2
// multichannel iir filter, transposed direct form ii, shared multiplier
// ----------------------------------------------------------------------------
// input channel: i_in_valid / o_in_stall with i_chan_in and i_sample_in (q1.23)
// output channel: o_out_valid / i_out_stall with o_chan_out, o_sample_out and
// o_saturated, one output transfer per input transfer, in order
// coefficients (q4.20) are written through i_cfg_we / i_cfg_idx / i_cfg_data;
// the user must write them only while the filter is idle; the block does not
// enforce it; index 0..3 is b0..b3, index 4..6 is a1..a3
// each sample runs through one 24x24 multiplier that forms 2*ORDER+1 products;
// the sequencer handles one sample at a time, from the input transfer to the
// output register; with a free output register a new input transfer is taken
// once the sequencer has loaded that register and returned to idle
// the delay memory holds ORDER words per channel, one read and one write port
// o_in_stall is high while a sample is in progress; a finished result sits in
// the output register and the next sample is taken meanwhile, but the sample
// after it waits until that register is free
// reset clears coefficients to b0 = 1.0 and all others 0, and marks every
// delay line as zero; no clearing pass is needed
// ----------------------------------------------------------------------------
module iir_filter_transposed_df2
    import iir_tdf2_pkg::*;
#(
    parameter int ORDER    = ORDER_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CIW-1:0]       i_cfg_idx,
    input  logic signed [SW-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [CHW-1:0]       i_chan_in,
    input  logic signed [SW-1:0] i_sample_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CHW-1:0]       o_chan_out,
    output logic signed [SW-1:0] o_sample_out,
    output logic                 o_saturated
);

`include "assert_macros.svh"

    t_cmd cmd;

    iir_tdf2_ctrl #(
        .ORDER (ORDER)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    iir_tdf2_dp #(
        .ORDER    (ORDER),
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_chan_in    (i_chan_in),
        .i_sample_in  (i_sample_in),
        .i_cmd        (cmd),
        .o_chan_out   (o_chan_out),
        .o_sample_out (o_sample_out),
        .o_saturated  (o_saturated)
    );

    `ASSERT_CLK(a_rw_apart, i_clk, i_rst_n, (cmd.rd_en && cmd.wr_en) |-> (cmd.rd_idx != cmd.wr_idx), "delay read and write hit the same tap")
    `ASSERT_CLK(a_idle_quiet, i_clk, i_rst_n, !o_in_stall |-> !(cmd.rd_en || cmd.wr_en || cmd.y_en || cmd.out_load), "datapath busy while idle")
    `ASSERT_CLK(a_out_free, i_clk, i_rst_n, cmd.out_load |-> (!o_out_valid || !i_out_stall), "output register overwritten while stalled")
    `ASSERT_CLK(a_busy_after_in, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "second transfer taken while a sample is in progress")

endmodule
